@@ hdl/srt_pkg.sv @@
`timescale 1ns / 1ps

package srt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int TIME_W = 20;
    localparam int ARR_W  = 16;
    localparam int REM_W  = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic              load;
        logic              start;
        logic              scan_rd;
        logic              commit;
        logic [SLOT_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

@@ hdl/srt_preemptive_scheduler.sv @@
`timescale 1ns / 1ps

// Shortest-remaining-time-first scheduler over NUM_SLOTS process slots. A load
// transaction (func 0) writes one slot and returns nothing. A tick transaction
// (func 1) returns one result in these steps: the accept, one remaining-time memory
// read per slot, a wait state (ST_LAST) for the last read to reach the compare, and
// the commit; the slot memory has a single read port, so slots are read one by one. The
// commit waits while an earlier result is still held on the output. The remaining-time
// table reads as zero after reset through a per-slot valid bit, so no clearing pass
// follows reset.
module srt_preemptive_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [3:0]                    slot,
    input  logic [srt_pkg::ARR_W-1:0]     arrival,
    input  logic [srt_pkg::REM_W-1:0]     service,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    running,
    output logic                          idle,
    output logic                          finished,
    output logic [srt_pkg::TIME_W-1:0]    finish_time,
    output logic [srt_pkg::TIME_W-1:0]    turnaround,
    output logic [srt_pkg::TIME_W-1:0]    now
);
    import srt_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .sts      (sts),
        .cmd      (cmd)
    );

    srt_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .slot        (slot),
        .arrival     (arrival),
        .service     (service),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .running     (running),
        .idle        (idle),
        .finished    (finished),
        .finish_time (finish_time),
        .turnaround  (turnaround),
        .now         (now)
    );

endmodule

@@ hdl/srt_ctrl.sv @@
`timescale 1ns / 1ps

module srt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             func,
    input  srt_pkg::dp_sts_t sts,
    output srt_pkg::dp_cmd_t cmd
);
    import srt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_LAST   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(NUM_SLOTS - 1);

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        cmd.idx     = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                // let the final read land in the compare stage
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ hdl/srt_dpath.sv @@
`timescale 1ns / 1ps

module srt_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  srt_pkg::dp_cmd_t             cmd,
    output srt_pkg::dp_sts_t             sts,
    input  logic [3:0]                   slot,
    input  logic [srt_pkg::ARR_W-1:0]    arrival,
    input  logic [srt_pkg::REM_W-1:0]    service,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [3:0]                   running,
    output logic                         idle,
    output logic                         finished,
    output logic [srt_pkg::TIME_W-1:0]   finish_time,
    output logic [srt_pkg::TIME_W-1:0]   turnaround,
    output logic [srt_pkg::TIME_W-1:0]   now
);
    import srt_pkg::*;

    // slot tables
    logic [REM_W-1:0] rem_mem [NUM_SLOTS];
    logic [ARR_W-1:0] arr_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] rem_vld_reg;

    // read stage
    logic              rd_vld_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic              rd_bit_reg;
    logic [REM_W-1:0]  rd_rem_reg;
    logic [ARR_W-1:0]  rd_arr_reg;

    // scan results
    logic              found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [REM_W-1:0]  best_rem_reg;
    logic [ARR_W-1:0]  best_arr_reg;
    logic              cur_elig_reg;
    logic [REM_W-1:0]  cur_rem_reg;
    logic [ARR_W-1:0]  cur_arr_reg;

    // scheduler state
    logic [SLOT_W-1:0] cur_proc_reg;
    logic              cur_valid_reg;
    logic [TIME_W-1:0] time_reg;

    // result register
    logic              out_valid_reg;
    logic [3:0]        running_reg;
    logic              idle_reg;
    logic              finished_reg;
    logic [TIME_W-1:0] finish_time_reg;
    logic [TIME_W-1:0] turnaround_reg;
    logic [TIME_W-1:0] now_reg;

    logic [REM_W-1:0]  rd_rem_eff;
    logic              rd_elig;
    logic              take_cur;
    logic [SLOT_W-1:0] sel_idx;
    logic [REM_W-1:0]  sel_rem;
    logic [ARR_W-1:0]  sel_arr;
    logic [REM_W-1:0]  new_rem;
    logic              done;
    logic [TIME_W-1:0] time_inc;
    logic [TIME_W-1:0] tat;
    logic              slot_ok;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_idx;
    logic [REM_W-1:0]  wr_rem;

    assign rd_rem_eff = rd_bit_reg ? rd_rem_reg : '0;
    assign rd_elig    = rd_vld_reg && (rd_rem_eff != '0)
                        && ({{(TIME_W-ARR_W){1'b0}}, rd_arr_reg} <= time_reg);

    // keep the running process unless someone else is strictly shorter
    assign take_cur = cur_valid_reg && cur_elig_reg && (cur_rem_reg <= best_rem_reg);
    assign sel_idx  = take_cur ? cur_proc_reg : best_idx_reg;
    assign sel_rem  = take_cur ? cur_rem_reg  : best_rem_reg;
    assign sel_arr  = take_cur ? cur_arr_reg  : best_arr_reg;
    assign new_rem  = sel_rem - 1'b1;
    assign done     = (new_rem == '0);
    assign time_inc = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 1'b1;
    assign tat      = time_inc - {{(TIME_W-ARR_W){1'b0}}, sel_arr};

    assign slot_ok = (8'(slot) < 8'(NUM_SLOTS));
    assign wr_en   = (cmd.load && slot_ok) || (cmd.commit && found_reg);
    assign wr_idx  = cmd.load ? SLOT_W'(slot) : sel_idx;
    assign wr_rem  = cmd.load ? service : new_rem;

    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rem_mem[wr_idx] <= wr_rem;
        end
        if (cmd.load && slot_ok)
        begin
            arr_mem[wr_idx] <= arrival;
        end
        if (cmd.scan_rd)
        begin
            rd_rem_reg <= rem_mem[cmd.idx];
            rd_arr_reg <= arr_mem[cmd.idx];
            rd_bit_reg <= rem_vld_reg[cmd.idx];
            rd_idx_reg <= cmd.idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_elig && (!found_reg || rd_rem_eff < best_rem_reg))
        begin
            best_idx_reg <= rd_idx_reg;
            best_rem_reg <= rd_rem_eff;
            best_arr_reg <= rd_arr_reg;
        end
        if (rd_vld_reg && (rd_idx_reg == cur_proc_reg))
        begin
            cur_rem_reg <= rd_rem_eff;
            cur_arr_reg <= rd_arr_reg;
        end
        if (cmd.commit)
        begin
            running_reg     <= found_reg ? 4'(sel_idx) : 4'd0;
            idle_reg        <= !found_reg;
            finished_reg    <= found_reg && done;
            finish_time_reg <= (found_reg && done) ? time_inc : '0;
            turnaround_reg  <= (found_reg && done) ? tat : '0;
            now_reg         <= time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_vld_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            cur_elig_reg  <= 1'b0;
            cur_proc_reg  <= '0;
            cur_valid_reg <= 1'b0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_rd;
            if (wr_en)
            begin
                rem_vld_reg[wr_idx] <= 1'b1;
            end
            if (cmd.start)
            begin
                found_reg    <= 1'b0;
                cur_elig_reg <= 1'b0;
            end
            else
            begin
                if (rd_elig)
                begin
                    found_reg <= 1'b1;
                end
                if (rd_vld_reg && (rd_idx_reg == cur_proc_reg))
                begin
                    cur_elig_reg <= rd_elig;
                end
            end
            if (cmd.commit)
            begin
                time_reg      <= time_inc;
                out_valid_reg <= 1'b1;
                if (found_reg)
                begin
                    cur_proc_reg  <= sel_idx;
                    cur_valid_reg <= !done;
                end
                else
                begin
                    cur_valid_reg <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign running     = running_reg;
    assign idle        = idle_reg;
    assign finished    = finished_reg;
    assign finish_time = finish_time_reg;
    assign turnaround  = turnaround_reg;
    assign now         = now_reg;

endmodule

@@ hdl/srt_checker.sv @@
`timescale 1ns / 1ps

module srt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        func,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [3:0]                  running,
    input logic                        idle,
    input logic                        finished,
    input logic [srt_pkg::TIME_W-1:0]  finish_time,
    input logic [srt_pkg::TIME_W-1:0]  turnaround,
    input logic [srt_pkg::TIME_W-1:0]  now
);
    import srt_pkg::*;

    // a stalled result holds its fields, turnaround apart
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(running) && $stable(idle)
            && $stable(finished) && $stable(finish_time) && $stable(now))
        else $error("result changed while stalled");

    // one tick in flight at a time
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == FUNC_TICK) |=> !in_ready)
        else $error("input accepted during a tick");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && idle |-> (running == 4'd0) && !finished)
        else $error("idle tick reports a process");

    a_nofin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !finished |-> (finish_time == '0) && (turnaround == '0))
        else $error("completion fields set without completion");

    a_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> (turnaround <= finish_time) && (finish_time != '0))
        else $error("completion fields inconsistent");

endmodule

bind srt_preemptive_scheduler srt_checker u_srt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .running     (running),
    .idle        (idle),
    .finished    (finished),
    .finish_time (finish_time),
    .turnaround  (turnaround),
    .now         (now)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import srt_pkg::*;

    localparam int GAP_MAX       = 13;
    localparam int SETTLE_CYCLES = 60;
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        logic [3:0]        running;
        logic              idle;
        logic              finished;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] now;
    } tick_report_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              func;
    logic [3:0]        slot;
    logic [ARR_W-1:0]  arrival;
    logic [REM_W-1:0]  service;
    logic              out_valid;
    logic              out_ready;
    logic [3:0]        running;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] now;

    // scheduler image kept by the testbench
    logic [REM_W-1:0]  sched_remaining [NUM_SLOTS];
    logic [ARR_W-1:0]  sched_arrival   [NUM_SLOTS];
    logic [3:0]        sched_current;
    logic              sched_current_valid;
    logic [TIME_W-1:0] sched_clock;

    tick_report_t pending_reports [$];
    int           mismatches;
    bit           tx_no_gap;
    bit           rx_no_stall;
    int           rx_hold_cycles;

    srt_preemptive_scheduler uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bit slot_eligible(input int k);
        return sched_remaining[k] != '0 && TIME_W'(sched_arrival[k]) <= sched_clock;
    endfunction

    function automatic tick_report_t schedule_tick();
        tick_report_t r;
        int           best;
        bit           found;
        logic [TIME_W-1:0] stamp;
        r     = '0;
        best  = 0;
        found = 1'b0;
        stamp = sched_clock;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (slot_eligible(k) && (!found || sched_remaining[k] < sched_remaining[best]))
            begin
                best  = k;
                found = 1'b1;
            end
        end
        // the running process holds the processor on a tie
        if (found && sched_current_valid && slot_eligible(sched_current) &&
            sched_remaining[sched_current] <= sched_remaining[best])
            best = sched_current;
        r.now       = stamp;
        sched_clock = (stamp == TIME_MAX) ? TIME_MAX : stamp + 1'b1;
        if (!found)
        begin
            sched_current_valid = 1'b0;
            r.idle = 1'b1;
            return r;
        end
        sched_current       = best[3:0];
        sched_current_valid = 1'b1;
        sched_remaining[best] = sched_remaining[best] - 1'b1;
        if (sched_remaining[best] == '0)
        begin
            r.finished    = 1'b1;
            r.finish_time = sched_clock;
            r.turnaround  = sched_clock - TIME_W'(sched_arrival[best]);
            sched_current_valid = 1'b0;
        end
        r.running = best[3:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_item(input logic f, input logic [3:0] s,
                             input logic [ARR_W-1:0] a, input logic [REM_W-1:0] v);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        func     <= f;
        slot     <= s;
        arrival  <= a;
        service  <= v;
        do @(posedge clk); while (!in_ready);
        if (f == FUNC_LOAD)
        begin
            sched_arrival[s]   = a;
            sched_remaining[s] = v;
        end
        else
            pending_reports.push_back(schedule_tick());
    endtask

    task automatic load_slot(input logic [3:0] s, input logic [ARR_W-1:0] a,
                             input logic [REM_W-1:0] v);
        send_item(FUNC_LOAD, s, a, v);
    endtask

    task automatic tick();
        send_item(FUNC_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        // loads return nothing, so give the block time to finish its last one
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_idle_ticks();
        tick();
        tick();
        settle();
    endtask

    task automatic test_single_process();
        load_slot(4'd0, 16'd0, 16'd2);
        repeat (3) tick();
        settle();
    endtask

    task automatic test_preemption();
        load_slot(4'd7, sched_clock[ARR_W-1:0], 16'd6);
        tick();
        load_slot(4'd3, sched_clock[ARR_W-1:0], 16'd2);
        tick();
        // equal remaining time: the running slot keeps the processor
        load_slot(4'd12, sched_clock[ARR_W-1:0], 16'd1);
        tick();
        tick();
        // nothing running, equal remaining time: lowest index wins
        load_slot(4'd2, sched_clock[ARR_W-1:0], 16'd5);
        tick();
        settle();
    endtask

    task automatic test_field_extremes();
        load_slot(4'd15, 16'hFFFF, 16'hFFFF);
        load_slot(4'd14, 16'd0, 16'd0);
        // reload the running slot so another slot becomes better
        load_slot(4'd2, 16'd0, 16'd40);
        tick();
        load_slot(4'd7, 16'd0, 16'd0);
        tick();
        load_slot(4'd2, 16'd0, 16'hFFFF);
        tick();
        settle();
    endtask

    task automatic send_random_item();
        int               pick;
        logic [ARR_W-1:0] a;
        logic [REM_W-1:0] v;
        if ($urandom_range(0, 99) >= 35)
        begin
            tick();
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 85)
            a = sched_clock[ARR_W-1:0] + ARR_W'($urandom_range(0, 24));
        else if (pick < 95)
            a = 16'($urandom);
        else
            a = '0;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            v = REM_W'($urandom_range(1, 24));
        else if (pick < 90)
            v = 16'($urandom);
        else if (pick < 95)
            v = '0;
        else
            v = 16'hFFFF;
        load_slot(4'($urandom_range(0, NUM_SLOTS - 1)), a, v);
    endtask

    task automatic test_random_workload();
        for (int n = 0; n < 1150; n++)
        begin
            if (n % 100 == 0)
            begin
                tx_no_gap   = ($urandom_range(0, 3) == 0);
                rx_no_stall = ($urandom_range(0, 3) == 0);
            end
            send_random_item();
        end
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
        settle();
    endtask

    task automatic test_output_backpressure();
        tx_no_gap      = 1'b1;
        rx_hold_cycles = 300;
        for (int n = 0; n < 120; n++)
            send_random_item();
        tx_no_gap = 1'b0;
        settle();
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int pause;
        out_ready = 1'b0;
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                pause          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                pause = rx_no_stall ? 0 : $urandom_range(0, GAP_MAX);
            if (pause > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (pause - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!(rst_n && out_valid && out_ready));
        end
    end

    initial
    begin
        tick_report_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                    report_mismatch("transaction with nothing pending, now", 32'(now), '0);
                else
                begin
                    want = pending_reports.pop_front();
                    if (running !== want.running)
                        report_mismatch("running", 32'(running), 32'(want.running));
                    if (idle !== want.idle)
                        report_mismatch("idle", 32'(idle), 32'(want.idle));
                    if (finished !== want.finished)
                        report_mismatch("finished", 32'(finished), 32'(want.finished));
                    if (finish_time !== want.finish_time)
                        report_mismatch("finish_time", 32'(finish_time),
                                        32'(want.finish_time));
                    if (turnaround !== want.turnaround)
                        report_mismatch("turnaround", 32'(turnaround),
                                        32'(want.turnaround));
                    if (now !== want.now)
                        report_mismatch("now", 32'(now), 32'(want.now));
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = FUNC_LOAD;
        slot           = '0;
        arrival        = '0;
        service        = '0;
        mismatches     = 0;
        tx_no_gap      = 1'b0;
        rx_no_stall    = 1'b0;
        rx_hold_cycles = 0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            sched_remaining[k] = '0;
            sched_arrival[k]   = '0;
        end
        sched_current       = '0;
        sched_current_valid = 1'b0;
        sched_clock         = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_ticks();
        test_single_process();
        test_preemption();
        test_field_extremes();
        test_random_workload();
        test_output_backpressure();

        if (mismatches == 0 && pending_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ srt_preemptive_scheduler.f @@
hdl/srt_pkg.sv
hdl/srt_ctrl.sv
hdl/srt_dpath.sv
hdl/srt_preemptive_scheduler.sv
hdl/srt_checker.sv
verif/tb_top.sv
